// ===== src/cdoa_pkg.sv =====
// Shared types, constants and calendar helpers for the calendar date offset adder.
`default_nettype none

package cdoa_pkg;

  // Field widths
  localparam int AMOUNT_W    = 16;
  localparam int YEAR_W      = 10;
  localparam int MON_W       = 4;
  localparam int MDAY_W      = 5;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int ACT_W       = 3;
  localparam int KIND_W      = 3;
  // Unwrapped year: a year-unit add can reach start year plus the full amount
  localparam int YEAR_FULL_W = AMOUNT_W + 1;
  // Day count: seven times the amount plus a day of month
  localparam int N_W         = AMOUNT_W + 3;
  // Year position inside the 400-year Gregorian cycle
  localparam int R400_W      = 9;
  // Quotient of the constant divisions (largest is amount / 12)
  localparam int Q_W         = 13;

  // Stream payload layout
  localparam int IN_W        = 48;
  localparam int OUT_W       = 32;
  localparam int IN_YEAR_LSB = AMOUNT_W;
  localparam int IN_MON_LSB  = IN_YEAR_LSB + YEAR_W;
  localparam int IN_MDAY_LSB = IN_MON_LSB + MON_W;
  localparam int IN_HOUR_LSB = IN_MDAY_LSB + MDAY_W;
  localparam int IN_MIN_LSB  = IN_HOUR_LSB + HOUR_W;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = YEAR_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOW_YEAR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOW_MONTH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOW_MDAY   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOW_HOUR   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NOW_MINUTE = 3'd4;

  // Unit codes on the input
  localparam logic [ACT_W-1:0] ACT_MINUTE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HOUR   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DAY    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WEEK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MONTH  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_YEAR   = 3'd5;

  // Job kinds handed from the front to the back
  localparam logic [KIND_W-1:0] KIND_MIN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HOUR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MON  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_YEAR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd5;

  // Calendar constants
  localparam logic [MON_W-1:0]  MON_JAN       = 4'd0;
  localparam logic [MON_W-1:0]  MON_FEB       = 4'd1;
  localparam logic [MON_W-1:0]  MON_DEC       = 4'd11;
  localparam logic [MON_W-1:0]  MONTHS        = 4'd12;
  localparam logic [MDAY_W-1:0] DAYS_LONG     = 5'd31;
  localparam logic [MDAY_W-1:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [N_W-1:0]    CYCLE_DAYS    = 19'd146097;
  localparam logic [N_W-1:0]    CYCLE_LIMIT   = 19'd146128;

  localparam logic [MDAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Job record in the queue between front and back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [N_W-1:0]    n;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  mon;
    logic [MDAY_W-1:0] mday;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  min;
    logic [R400_W-1:0] r400;
  } job_t;

  // Current time registers
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  mon;
    logic [MDAY_W-1:0] mday;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  min;
  } now_t;

  // Leap year from the position in the 400-year cycle
  function automatic logic is_leap(input logic [R400_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != R400_W'(100)) && (r != R400_W'(200)) &&
           (r != R400_W'(300));
  endfunction

  // Month length; months beyond December count as long months
  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0]  mon,
                                                 input logic [R400_W-1:0] r);
    logic [MDAY_W-1:0] len;
    if (mon >= MONTHS) begin
      len = DAYS_LONG;
    end else if ((mon == MON_FEB) && is_leap(r)) begin
      len = FEB_LEAP_DAYS;
    end else begin
      len = MONTH_DAYS[mon];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/cdoa_front.sv =====
// Front end: takes input transfers, classifies the unit and prepares the job record.
`default_nettype none

module cdoa_front (
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // in_tdata: amount, start_year, start_month, start_mday, start_hour, start_minute
  input  wire logic [cdoa_pkg::IN_W-1:0]   in_tdata,
  // in_tuser: action
  input  wire logic [cdoa_pkg::ACT_W-1:0]  in_tuser,
  input  wire logic                        q_full,
  output logic                             q_push,
  output cdoa_pkg::job_t                   q_job
);
  import cdoa_pkg::*;

  logic [AMOUNT_W-1:0] amount;
  logic [YEAR_W-1:0]   year;
  logic [MON_W-1:0]    mon;
  logic [MDAY_W-1:0]   mday;
  logic [HOUR_W-1:0]   hour;
  logic [MIN_W-1:0]    min;
  logic [N_W-1:0]      amount7;
  logic [YEAR_W:0]     ys;

  // Field unpacking
  assign amount = in_tdata[0 +: AMOUNT_W];
  assign year   = in_tdata[IN_YEAR_LSB +: YEAR_W];
  assign mon    = in_tdata[IN_MON_LSB +: MON_W];
  assign mday   = in_tdata[IN_MDAY_LSB +: MDAY_W];
  assign hour   = in_tdata[IN_HOUR_LSB +: HOUR_W];
  assign min    = in_tdata[IN_MIN_LSB +: MIN_W];

  // Handshake: accept while the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Seven times the amount for the week unit
  assign amount7 = {amount, 3'b000} - N_W'(amount);

  // Position of the start year in the 400-year cycle: (year + 1900) mod 400
  assign ys = {1'b0, year} + (YEAR_W+1)'(300);

  always_comb begin
    q_job.year = year;
    q_job.mon  = mon;
    q_job.mday = mday;
    q_job.hour = hour;
    q_job.min  = min;

    if (ys >= (YEAR_W+1)'(1200)) begin
      q_job.r400 = R400_W'(ys - (YEAR_W+1)'(1200));
    end else if (ys >= (YEAR_W+1)'(800)) begin
      q_job.r400 = R400_W'(ys - (YEAR_W+1)'(800));
    end else if (ys >= (YEAR_W+1)'(400)) begin
      q_job.r400 = R400_W'(ys - (YEAR_W+1)'(400));
    end else begin
      q_job.r400 = R400_W'(ys);
    end

    // Unit decode and first sum
    case (in_tuser)
      ACT_MINUTE: begin
        q_job.kind = KIND_MIN;
        q_job.n    = N_W'(amount) + N_W'(min);
      end
      ACT_HOUR: begin
        q_job.kind = KIND_HOUR;
        q_job.n    = N_W'(amount) + N_W'(hour);
      end
      ACT_DAY: begin
        q_job.kind = KIND_DAY;
        q_job.n    = N_W'(amount) + N_W'(mday);
      end
      ACT_WEEK: begin
        q_job.kind = KIND_DAY;
        q_job.n    = amount7 + N_W'(mday);
      end
      ACT_MONTH: begin
        q_job.kind = KIND_MON;
        q_job.n    = N_W'(amount) + N_W'(mon);
      end
      ACT_YEAR: begin
        q_job.kind = KIND_YEAR;
        q_job.n    = N_W'(amount);
      end
      default: begin
        q_job.kind = KIND_NONE;
        q_job.n    = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/cdoa_queue.sv =====
// Two-entry job queue between the front and the back.
`default_nettype none

module cdoa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cdoa_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output cdoa_pkg::job_t      pop_job,
  output logic                not_empty
);
  import cdoa_pkg::*;

  job_t        entry_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = entry_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== src/cdoa_back.sv =====
// Back end: carry sequencer (constant divisions, calendar walk) and result register.
`default_nettype none

module cdoa_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cdoa_pkg::job_t             job,
  input  wire logic                       job_valid,
  output logic                            job_pop,
  input  wire cdoa_pkg::now_t             now,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [cdoa_pkg::OUT_W-1:0]      out_tdata
);
  import cdoa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] DIV_60 = 2'd0;
  localparam logic [1:0] DIV_24 = 2'd1;
  localparam logic [1:0] DIV_12 = 2'd2;

  // Reciprocals: x/3 = (x * 0xAAAB) >> 17, x/15 = (x * 0x8889) >> 19
  localparam logic [15:0] RECIP_3  = 16'hAAAB;
  localparam logic [15:0] RECIP_15 = 16'h8889;

  // Control registers
  logic [2:0]             state_r;
  logic [2:0]             state_nxt;
  logic                   out_tvalid_r;
  logic                   out_tvalid_nxt;
  // Datapath registers
  logic [1:0]             div_sel_r;
  logic [1:0]             div_sel_nxt;
  logic [N_W-1:0]         n_r;
  logic [N_W-1:0]         n_nxt;
  logic [Q_W-1:0]         q_r;
  logic [Q_W-1:0]         q_nxt;
  logic [YEAR_FULL_W-1:0] yr_r;
  logic [YEAR_FULL_W-1:0] yr_nxt;
  logic [R400_W-1:0]      r_r;
  logic [R400_W-1:0]      r_nxt;
  logic [MON_W-1:0]       mon_r;
  logic [MON_W-1:0]       mon_nxt;
  logic [MDAY_W-1:0]      mday_r;
  logic [MDAY_W-1:0]      mday_nxt;
  logic [HOUR_W-1:0]      hour_r;
  logic [HOUR_W-1:0]      hour_nxt;
  logic [MIN_W-1:0]       min_r;
  logic [MIN_W-1:0]       min_nxt;
  logic [OUT_W-1:0]       out_tdata_r;
  logic [OUT_W-1:0]       out_tdata_nxt;

  // Shared datapath
  logic [14:0]            mul_x;
  logic [15:0]            mul_c;
  logic [30:0]            prod;
  logic [N_W-1:0]         q_times_d;
  logic [N_W-1:0]         rem;
  logic [MDAY_W-1:0]      mlen;
  logic [N_W-1:0]         len1;
  logic [N_W-1:0]         len4;
  logic [N_W-1:0]         len100;
  logic [R400_W:0]        m4;
  logic [R400_W-1:0]      r_p1;
  logic [R400_W-1:0]      r_p4;
  logic [R400_W-1:0]      r_p100;
  logic [YEAR_W-1:0]      end_year;
  logic                   too_late;
  logic                   year_overflow;
  logic                   out_free;

  // Step through the 400-year cycle position modulo 400
  function automatic logic [R400_W-1:0] r_add(input logic [R400_W-1:0] r,
                                             input logic [6:0]        k);
    logic [R400_W:0] s;
    s = {1'b0, r} + (R400_W+1)'(k);
    if (s >= (R400_W+1)'(400)) begin
      s = s - (R400_W+1)'(400);
    end
    return R400_W'(s);
  endfunction

  // Constant divider: one multiply by the reciprocal
  always_comb begin
    case (div_sel_r)
      DIV_24: begin
        mul_x = 15'(n_r >> 3);
        mul_c = RECIP_3;
      end
      DIV_12: begin
        mul_x = 15'(n_r >> 2);
        mul_c = RECIP_3;
      end
      default: begin
        mul_x = 15'(n_r >> 2);
        mul_c = RECIP_15;
      end
    endcase
  end

  assign prod = 31'(mul_x) * 31'(mul_c);

  // Quotient times divisor by shift and add (shift and subtract for 60), then remainder
  always_comb begin
    case (div_sel_r)
      DIV_24:  q_times_d = (N_W'(q_r) << 4) + (N_W'(q_r) << 3);
      DIV_12:  q_times_d = (N_W'(q_r) << 3) + (N_W'(q_r) << 2);
      default: q_times_d = (N_W'(q_r) << 6) - (N_W'(q_r) << 2);
    endcase
  end

  assign rem = n_r - q_times_d;

  // Span lengths from January of the current year
  assign mlen   = month_len(mon_r, r_r);
  assign len1   = is_leap(r_r) ? N_W'(366) : N_W'(365);
  assign m4     = ({1'b0, r_r} + (R400_W+1)'(3)) & ~(R400_W+1)'(3);
  assign len4   = ((m4 == (R400_W+1)'(100)) || (m4 == (R400_W+1)'(200)) ||
                   (m4 == (R400_W+1)'(300))) ? N_W'(1460) : N_W'(1461);
  assign len100 = ((r_r == '0) || (r_r > R400_W'(300))) ? N_W'(36525) : N_W'(36524);
  assign r_p1   = r_add(r_r, 7'd1);
  assign r_p4   = r_add(r_r, 7'd4);
  assign r_p100 = r_add(r_r, 7'd100);

  // Result fields and comparison with the current time
  assign end_year      = yr_r[YEAR_W-1:0];
  assign year_overflow = |yr_r[YEAR_FULL_W-1:YEAR_W];
  assign too_late      = {now.year, now.mon, now.mday, now.hour, now.min} >
                         {end_year, mon_r, mday_r, hour_r, min_r};
  assign out_free      = !out_tvalid_r || out_tready;

  assign job_pop    = (state_r == ST_IDLE) && job_valid;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    div_sel_nxt    = div_sel_r;
    n_nxt          = n_r;
    q_nxt          = q_r;
    yr_nxt         = yr_r;
    r_nxt          = r_r;
    mon_nxt        = mon_r;
    mday_nxt       = mday_r;
    hour_nxt       = hour_r;
    min_nxt        = min_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          n_nxt    = job.n;
          yr_nxt   = YEAR_FULL_W'(job.year);
          r_nxt    = job.r400;
          mon_nxt  = job.mon;
          mday_nxt = job.mday;
          hour_nxt = job.hour;
          min_nxt  = job.min;
          case (job.kind)
            KIND_MIN: begin
              div_sel_nxt = DIV_60;
              state_nxt   = ST_MUL;
            end
            KIND_HOUR: begin
              div_sel_nxt = DIV_24;
              state_nxt   = ST_MUL;
            end
            KIND_DAY: begin
              state_nxt = ST_WALK;
            end
            KIND_MON: begin
              div_sel_nxt = DIV_12;
              state_nxt   = ST_MUL;
            end
            KIND_YEAR: begin
              yr_nxt    = YEAR_FULL_W'(job.year) + YEAR_FULL_W'(job.n);
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_MUL: begin
        if (div_sel_r == DIV_60) begin
          q_nxt = Q_W'(prod >> 19);
        end else begin
          q_nxt = Q_W'(prod >> 17);
        end
        state_nxt = ST_REM;
      end

      ST_REM: begin
        case (div_sel_r)
          DIV_24: begin
            hour_nxt = rem[HOUR_W-1:0];
            if (n_r > N_W'(23)) begin
              n_nxt     = N_W'(q_r) + N_W'(mday_r);
              state_nxt = ST_WALK;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          DIV_12: begin
            mon_nxt   = rem[MON_W-1:0];
            yr_nxt    = yr_r + YEAR_FULL_W'(q_r);
            state_nxt = ST_DONE;
          end
          default: begin
            min_nxt = rem[MIN_W-1:0];
            if (n_r > N_W'(59)) begin
              n_nxt       = N_W'(q_r) + N_W'(hour_r);
              div_sel_nxt = DIV_24;
              state_nxt   = ST_MUL;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        endcase
      end

      // One calendar step per cycle: whole cycles, centuries, four-year blocks,
      // years (from January only) or a single month
      ST_WALK: begin
        if ((mon_r < MONTHS) && (n_r > CYCLE_LIMIT)) begin
          n_nxt  = n_r - CYCLE_DAYS;
          yr_nxt = yr_r + YEAR_FULL_W'(400);
        end else if ((mon_r == MON_JAN) && (n_r > len100)) begin
          n_nxt  = n_r - len100;
          yr_nxt = yr_r + YEAR_FULL_W'(100);
          r_nxt  = r_p100;
        end else if ((mon_r == MON_JAN) && (n_r > len4)) begin
          n_nxt  = n_r - len4;
          yr_nxt = yr_r + YEAR_FULL_W'(4);
          r_nxt  = r_p4;
        end else if ((mon_r == MON_JAN) && (n_r > len1)) begin
          n_nxt  = n_r - len1;
          yr_nxt = yr_r + YEAR_FULL_W'(1);
          r_nxt  = r_p1;
        end else if (n_r > N_W'(mlen)) begin
          n_nxt = n_r - N_W'(mlen);
          if (mon_r >= MON_DEC) begin
            // December and out-of-range months wrap into the next year
            mon_nxt = mon_r - MON_DEC;
            yr_nxt  = yr_r + YEAR_FULL_W'(1);
            r_nxt   = r_p1;
          end else begin
            mon_nxt = mon_r + MON_W'(1);
          end
        end else begin
          mday_nxt  = n_r[MDAY_W-1:0];
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {year_overflow, too_late, min_r, hour_r, mday_r, mon_r, end_year};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_sel_r   <= div_sel_nxt;
    n_r         <= n_nxt;
    q_r         <= q_nxt;
    yr_r        <= yr_nxt;
    r_r         <= r_nxt;
    mon_r       <= mon_nxt;
    mday_r      <= mday_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

`default_nettype wire

// ===== src/calendar_date_offset_adder_unit.sv =====
// Top level of the calendar date offset adder: current-time registers, front, queue, back.
// Year and unused units go straight to the output stage; month, hour and minute units pass
// through reciprocal-multiply constant divisions, and day carries then take a calendar walk; the back
// walks one calendar step (400 years, 100 years, 4 years, 1 year or one month) a cycle.
// Throughput: one item per back-end pass; a two-entry queue takes new items meanwhile.
// Reset: synchronous, active low; clears the queue and sequencer and sets the current time to day 1.
`default_nettype none

module calendar_date_offset_adder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata: amount, start_year, start_month, start_mday, start_hour, start_minute
  input  wire logic [cdoa_pkg::IN_W-1:0]        in_tdata,
  // in_tuser: action
  input  wire logic [cdoa_pkg::ACT_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata: end_year, end_month, end_mday, end_hour, end_minute, too_late, year_overflow
  output logic [cdoa_pkg::OUT_W-1:0]            out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [cdoa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [cdoa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cdoa_pkg::*;

  now_t  now_r;
  job_t  front_job;
  job_t  queue_job;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;

  // Current-time registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r.year <= '0;
      now_r.mon  <= '0;
      now_r.mday <= MDAY_W'(1);
      now_r.hour <= '0;
      now_r.min  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NOW_YEAR:   now_r.year <= cfg_wdata[YEAR_W-1:0];
        CFG_NOW_MONTH:  now_r.mon  <= cfg_wdata[MON_W-1:0];
        CFG_NOW_MDAY:   now_r.mday <= cfg_wdata[MDAY_W-1:0];
        CFG_NOW_HOUR:   now_r.hour <= cfg_wdata[HOUR_W-1:0];
        CFG_NOW_MINUTE: now_r.min  <= cfg_wdata[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cdoa_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (front_job)
  );

  cdoa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (queue_job),
    .not_empty (q_not_empty)
  );

  cdoa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (queue_job),
    .job_valid  (q_not_empty),
    .job_pop    (q_pop),
    .now        (now_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
